// ===== hdl/csvt_pkg.sv =====
// Package for the CSV byte tokenizer.
// Holds the character constants, the result kind codes, the result structs and the output queue status struct.
// No dependencies.
package csvt_pkg;

	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] SEP_RESET  = 8'd44;

	typedef enum logic [1:0] {
		K_BYTE       = 2'd0,
		K_FIELD_END  = 2'd1,
		K_RECORD_END = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data_byte;
		logic       run_last;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} step_out_t;

	typedef struct packed {
		logic can_load;
		logic pend_vld;
	} outq_status_t;

endpackage

// ===== hdl/csvt_step.sv =====
// Per-byte tokenizer step: parse mode register and the decode of one byte into
// zero, one or two results. Depends on csvt_pkg.
module csvt_step (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic [7:0]          ch,
	input  logic                fin,
	input  logic [7:0]          sep,
	output csvt_pkg::step_out_t res
);

	typedef enum logic [2:0] {
		M_LINE_START  = 3'd0,
		M_FIELD_START = 3'd1,
		M_PLAIN       = 3'd2,
		M_QUOTED      = 3'd3,
		M_QUOTE_SEEN  = 3'd4
	} mode_t;

	mode_t                 mode_q;
	mode_t                 mode_mid;
	mode_t                 mode_nxt;
	logic                  has0;
	csvt_pkg::kind_t       kind0;
	logic                  fin_end;
	logic                  is_quote;
	logic                  is_sep;
	csvt_pkg::result_t     rec_end;
	csvt_pkg::result_t     chr_res;

	assign is_quote = (ch == csvt_pkg::CH_QUOTE);
	assign is_sep   = (ch == sep);

	always_comb begin
		has0     = 1'b0;
		kind0    = csvt_pkg::K_BYTE;
		mode_mid = mode_q;
		if (ch == csvt_pkg::CH_NEWLINE) begin
			has0     = (mode_q != M_LINE_START);
			kind0    = csvt_pkg::K_RECORD_END;
			mode_mid = M_LINE_START;
		end else begin
			unique case (mode_q)
				M_LINE_START, M_FIELD_START: begin
					if (is_quote) begin
						mode_mid = M_QUOTED;
					end else if (is_sep) begin
						has0     = 1'b1;
						kind0    = csvt_pkg::K_FIELD_END;
						mode_mid = M_FIELD_START;
					end else begin
						has0     = 1'b1;
						mode_mid = M_PLAIN;
					end
				end
				M_QUOTED: begin
					if (is_quote) begin
						mode_mid = M_QUOTE_SEEN;
					end else begin
						has0 = 1'b1;
					end
				end
				M_QUOTE_SEEN: begin
					if (is_quote) begin
						has0     = 1'b1;
						mode_mid = M_QUOTED;
					end else if (is_sep) begin
						has0     = 1'b1;
						kind0    = csvt_pkg::K_FIELD_END;
						mode_mid = M_FIELD_START;
					end else begin
						has0     = 1'b1;
						mode_mid = M_PLAIN;
					end
				end
				default: begin
					if (is_sep) begin
						has0     = 1'b1;
						kind0    = csvt_pkg::K_FIELD_END;
						mode_mid = M_FIELD_START;
					end else begin
						has0     = 1'b1;
						mode_mid = M_PLAIN;
					end
				end
			endcase
		end
	end

	assign fin_end  = fin && (mode_mid != M_LINE_START);
	assign mode_nxt = fin_end ? M_LINE_START : mode_mid;

	always_comb begin
		rec_end.kind      = csvt_pkg::K_RECORD_END;
		rec_end.data_byte = 8'd0;
		rec_end.run_last  = 1'b1;
		chr_res.kind      = kind0;
		chr_res.data_byte = (kind0 == csvt_pkg::K_BYTE) ? ch : 8'd0;
		chr_res.run_last  = !fin_end;
		res.count = {1'b0, has0} + {1'b0, fin_end};
		res.r0    = has0 ? chr_res : rec_end;
		res.r1    = rec_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_LINE_START;
		end else if (adv) begin
			mode_q <= mode_nxt;
		end
	end

endmodule

// ===== hdl/csvt_outq.sv =====
// Output register with one spare slot for the second result of a byte.
// Depends on csvt_pkg.
module csvt_outq (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   load,
	input  csvt_pkg::step_out_t    res,
	input  logic                   ready,
	output logic                   valid,
	output csvt_pkg::result_t      head,
	output csvt_pkg::outq_status_t status
);

	csvt_pkg::result_t out_q;
	csvt_pkg::result_t pend_q;
	logic              out_vld_q;
	logic              pend_vld_q;
	logic              load_any;

	assign load_any        = load && (res.count != 2'd0);
	assign status.can_load = !pend_vld_q && (!out_vld_q || ready);
	assign status.pend_vld = pend_vld_q;
	assign valid           = out_vld_q;
	assign head            = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			pend_vld_q <= 1'b0;
		end else if (load_any) begin
			out_vld_q  <= 1'b1;
			pend_vld_q <= (res.count == 2'd2);
		end else if (load) begin
			out_vld_q <= 1'b0;
		end else if (out_vld_q && ready) begin
			out_vld_q  <= pend_vld_q;
			pend_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_any) begin
			out_q  <= res.r0;
			pend_q <= res.r1;
		end else if (out_vld_q && ready && pend_vld_q) begin
			out_q <= pend_q;
		end
	end

endmodule

// ===== hdl/csv_byte_tokenizer_top.sv =====
// Top level of the CSV byte tokenizer: input stage, separator register,
// step decode and output queue. Depends on csvt_pkg, csvt_step, csvt_outq.
//
//  channel  | dir | handshake         | payload
//  ---------+-----+-------------------+--------------------------------------
//  s_*      | in  | s_tvalid/s_tready | s_tdata = ch, s_tlast = is_final
//  m_*      | out | m_tvalid/m_tready | m_tdata = data_byte, m_tuser = kind,
//           |     |                   | m_tlast = run_last
//  cfg_*    | in  | cfg_valid/ready   | cfg_data = separator
//
// One byte per cycle while the output queue can load; a byte enters the input
// stage and is decoded against the mode register; its results load the queue.
// A byte with two results holds the input stage for one extra output beat.
// Reset clears the mode to line start and the separator to ','.
// A stalled output holds up to two results, then back-pressures the input.
module csv_byte_tokenizer_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] ch
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] data_byte
	output logic [1:0] m_tuser,   // [1:0] kind
	output logic       m_tlast,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);

	logic                   vld_s1;
	logic [7:0]             ch_s1;
	logic                   fin_s1;
	logic [7:0]             sep_q;
	logic                   adv;
	csvt_pkg::step_out_t    res;
	csvt_pkg::result_t      head;
	csvt_pkg::outq_status_t oq_st;

	assign cfg_ready = 1'b1;
	assign adv       = vld_s1 && oq_st.can_load;
	assign s_tready  = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			sep_q  <= csvt_pkg::SEP_RESET;
		end else begin
			if (s_tready) begin
				vld_s1 <= s_tvalid;
			end
			if (cfg_valid && cfg_ready) begin
				sep_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ch_s1  <= s_tdata;
			fin_s1 <= s_tlast;
		end
	end

	csvt_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.ch     (ch_s1),
		.fin    (fin_s1),
		.sep    (sep_q),
		.res    (res)
	);

	csvt_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (adv),
		.res    (res),
		.ready  (m_tready),
		.valid  (m_tvalid),
		.head   (head),
		.status (oq_st)
	);

	assign m_tdata = head.data_byte;
	assign m_tuser = head.kind;
	assign m_tlast = head.run_last;

`ifndef ASSERT_OFF
	a_spare_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		oq_st.pend_vld |-> m_tvalid)
		else $error("spare result held without a head result");

	a_marker_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != csvt_pkg::K_BYTE)) |-> (m_tdata == 8'd0))
		else $error("marker beat carries nonzero data");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid && !vld_s1) |=> !m_tvalid)
		else $error("result beat appeared without an input byte");

	a_spare_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && oq_st.pend_vld) |-> !m_tlast)
		else $error("first of two results flagged last");
`endif

endmodule

// ===== tb/csv_byte_tokenizer_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the CSV byte tokenizer: watches the byte, result and separator channels,
// predicts the tokens of each accepted byte and compares them beat by beat.
// Depends on csvt_pkg.
module csv_byte_tokenizer_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] ch
	input  logic       s_tlast,
	input  logic       m_tvalid,
	input  logic       m_tready,
	input  logic [7:0] m_tdata,   // [7:0] data_byte
	input  logic [1:0] m_tuser,   // [1:0] kind
	input  logic       m_tlast,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic [7:0] cfg_data,
	output int         fail_count,
	output int         pending_count,
	output int         bytes_in,
	output int         results_out,
	output int         records_out
);

	typedef enum logic [2:0] {
		MD_LINE_START  = 3'd0,
		MD_FIELD_START = 3'd1,
		MD_PLAIN       = 3'd2,
		MD_QUOTED      = 3'd3,
		MD_QUOTE_SEEN  = 3'd4
	} tok_mode_t;

	tok_mode_t          mode_q;
	logic [7:0]         separator_q;
	csvt_pkg::result_t  pending_results [$];

	initial begin
		fail_count    = 0;
		pending_count = 0;
		bytes_in      = 0;
		results_out   = 0;
		records_out   = 0;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		fail_count++;
	endtask

	function automatic csvt_pkg::result_t make_token(input csvt_pkg::kind_t k,
		input logic [7:0] b);
		csvt_pkg::result_t r;
		r.kind      = k;
		r.data_byte = (k == csvt_pkg::K_BYTE) ? b : 8'h00;
		r.run_last  = 1'b0;
		return r;
	endfunction

	function automatic void tokenize_byte(input logic [7:0] ch, input logic fin);
		csvt_pkg::result_t toks [2];
		int                n;
		n = 0;
		if (ch == csvt_pkg::CH_NEWLINE) begin
			if (mode_q != MD_LINE_START) begin
				toks[n] = make_token(csvt_pkg::K_RECORD_END, 8'h00);
				n++;
			end
			mode_q = MD_LINE_START;
		end else begin
			case (mode_q)
				MD_LINE_START, MD_FIELD_START: begin
					if (ch == csvt_pkg::CH_QUOTE) begin
						mode_q = MD_QUOTED;
					end else if (ch == separator_q) begin
						toks[n] = make_token(csvt_pkg::K_FIELD_END, 8'h00);
						n++;
						mode_q = MD_FIELD_START;
					end else begin
						toks[n] = make_token(csvt_pkg::K_BYTE, ch);
						n++;
						mode_q = MD_PLAIN;
					end
				end
				MD_QUOTED: begin
					if (ch == csvt_pkg::CH_QUOTE) begin
						mode_q = MD_QUOTE_SEEN;
					end else begin
						toks[n] = make_token(csvt_pkg::K_BYTE, ch);
						n++;
					end
				end
				MD_QUOTE_SEEN: begin
					if (ch == csvt_pkg::CH_QUOTE) begin
						toks[n] = make_token(csvt_pkg::K_BYTE, ch);
						n++;
						mode_q = MD_QUOTED;
					end else if (ch == separator_q) begin
						toks[n] = make_token(csvt_pkg::K_FIELD_END, 8'h00);
						n++;
						mode_q = MD_FIELD_START;
					end else begin
						toks[n] = make_token(csvt_pkg::K_BYTE, ch);
						n++;
						mode_q = MD_PLAIN;
					end
				end
				default: begin
					if (ch == separator_q) begin
						toks[n] = make_token(csvt_pkg::K_FIELD_END, 8'h00);
						n++;
						mode_q = MD_FIELD_START;
					end else begin
						toks[n] = make_token(csvt_pkg::K_BYTE, ch);
						n++;
						mode_q = MD_PLAIN;
					end
				end
			endcase
		end
		if (fin && mode_q != MD_LINE_START) begin
			toks[n] = make_token(csvt_pkg::K_RECORD_END, 8'h00);
			n++;
			mode_q = MD_LINE_START;
		end
		for (int i = 0; i < n; i++) begin
			toks[i].run_last = (i == n - 1);
			pending_results = {pending_results, toks[i]};
		end
	endfunction

	task automatic check_token();
		csvt_pkg::result_t exp;
		if (pending_results.size() == 0) begin
			report_mismatch($sformatf("result with none expected: kind %0d byte %02h last %0b",
				m_tuser, m_tdata, m_tlast));
		end else begin
			exp = pending_results.pop_front();
			if (m_tuser !== exp.kind)
				report_mismatch($sformatf("kind %0d, expected %0d", m_tuser, exp.kind));
			if (m_tdata !== exp.data_byte)
				report_mismatch($sformatf("data_byte %02h, expected %02h", m_tdata,
					exp.data_byte));
			if (m_tlast !== exp.run_last)
				report_mismatch($sformatf("run_last %0b, expected %0b", m_tlast,
					exp.run_last));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      = MD_LINE_START;
			separator_q = csvt_pkg::SEP_RESET;
			pending_results.delete();
			pending_count = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_out++;
				if (m_tuser == csvt_pkg::K_RECORD_END)
					records_out++;
				check_token();
			end
			if (cfg_valid && cfg_ready)
				separator_q = cfg_data;
			if (s_tvalid && s_tready) begin
				bytes_in++;
				tokenize_byte(s_tdata, s_tlast);
			end
			pending_count = pending_results.size();
		end
	end

endmodule

// ===== tb/csv_byte_tokenizer_top_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for csv_byte_tokenizer_top: drives directed and random CSV byte streams
// under several separators with random idling, and gives the verdict.
// Depends on csvt_pkg, csv_byte_tokenizer_top and csv_byte_tokenizer_checker.
module csv_byte_tokenizer_top_tb;

	localparam logic [7:0] CH_NEWLINE = csvt_pkg::CH_NEWLINE;
	localparam logic [7:0] CH_QUOTE   = csvt_pkg::CH_QUOTE;
	localparam logic [7:0] SEP_RESET  = csvt_pkg::SEP_RESET;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam int NUM_PHASES   = 8;
	localparam int PHASE_BYTES  = 136;
	localparam int HOLD_CYCLES  = 150;
	localparam int HOLD_AT_BYTE = 400;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic       s_tlast = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic [1:0] m_tuser;
	logic       m_tlast;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_data = 8'h00;

	int fail_count, pending_count, bytes_in, results_out, records_out;
	int sent_count = 0;
	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;
	bit rx_hold = 1'b0;
	logic [7:0] cur_sep = SEP_RESET;

	logic [7:0] phase_seps [NUM_PHASES] = '{CH_COMMA, CH_SEMI, 8'h00, 8'hFF, CH_NEWLINE,
		CH_QUOTE, CH_TAB, CH_COMMA};

	// {is_final, ch}
	logic [8:0] directed_beats [26] = '{
		{1'b0, CH_NEWLINE}, {1'b0, 8'h61},      {1'b0, CH_QUOTE},   {1'b0, CH_COMMA},
		{1'b0, CH_COMMA},   {1'b0, CH_QUOTE},   {1'b0, CH_QUOTE},   {1'b0, CH_QUOTE},
		{1'b0, CH_COMMA},   {1'b0, CH_QUOTE},   {1'b0, CH_COMMA},   {1'b0, CH_QUOTE},
		{1'b0, CH_QUOTE},   {1'b0, 8'h78},      {1'b0, CH_QUOTE},   {1'b0, CH_NEWLINE},
		{1'b0, 8'h00},      {1'b0, 8'hFF},      {1'b1, CH_NEWLINE}, {1'b1, CH_NEWLINE},
		{1'b0, CH_QUOTE},   {1'b0, CH_NEWLINE}, {1'b0, CH_QUOTE},   {1'b0, 8'h62},
		{1'b0, CH_NEWLINE}, {1'b1, 8'h6B}
	};

	csv_byte_tokenizer_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	csv_byte_tokenizer_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tlast       (s_tlast),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.m_tlast       (m_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending_count (pending_count),
		.bytes_in      (bytes_in),
		.results_out   (results_out),
		.records_out   (records_out)
	);

	always #10 clk = ~clk;

	initial begin
		#4_000_000;
		$display("csv_byte_tokenizer_top test failed");
		$finish;
	end

	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = rx_idle ? $urandom_range(0, 4) : 0;
			if (gap > 0 || rx_hold) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
				while (rx_hold) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// long output stall while the byte stream keeps coming
	initial begin
		wait (sent_count >= HOLD_AT_BYTE);
		@(negedge clk);
		rx_hold = 1'b1;
		repeat (HOLD_CYCLES) @(negedge clk);
		rx_hold = 1'b0;
	end

	task automatic send_byte(input logic [7:0] ch, input logic fin);
		int gap;
		gap = tx_idle ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= ch;
		s_tlast  <= fin;
		do @(posedge clk); while (!s_tready);
		sent_count++;
	endtask

	task automatic write_separator(input logic [7:0] sep);
		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending_count != 0) @(negedge clk);
		repeat (8) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= sep;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_sep = sep;
	endtask

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		if (b == CH_NEWLINE || b == CH_QUOTE || b == cur_sep)
			b = 8'h61 + 8'($urandom_range(0, 25));
		return b;
	endfunction

	function automatic logic [7:0] quoted_byte();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		if (b == CH_NEWLINE || b == CH_QUOTE)
			b = 8'h41 + 8'($urandom_range(0, 25));
		return b;
	endfunction

	task automatic send_record();
		int n_fields, len, ending;
		n_fields = $urandom_range(1, 4);
		for (int f = 0; f < n_fields; f++) begin
			if (f > 0)
				send_byte(cur_sep, 1'b0);
			len = $urandom_range(0, 5);
			if ($urandom_range(0, 2) == 0) begin
				send_byte(CH_QUOTE, 1'b0);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 5) == 0) begin
						send_byte(CH_QUOTE, 1'b0);
						send_byte(CH_QUOTE, 1'b0);
					end else if ($urandom_range(0, 7) == 0) begin
						send_byte(cur_sep, 1'b0);
					end else begin
						send_byte(quoted_byte(), 1'b0);
					end
				end
				send_byte(CH_QUOTE, 1'b0);
				if ($urandom_range(0, 4) == 0)
					send_byte(plain_byte(), 1'b0);
			end else begin
				for (int i = 0; i < len; i++)
					send_byte(plain_byte(), 1'b0);
			end
		end
		ending = $urandom_range(0, 9);
		if (ending == 0)
			send_byte(CH_NEWLINE, 1'b1);
		else if (ending == 1)
			send_byte(plain_byte(), 1'b1);
		else
			send_byte(CH_NEWLINE, 1'b0);
	endtask

	task automatic send_noise();
		int n;
		logic [7:0] b;
		n = $urandom_range(1, 6);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 3))
				0: b = CH_QUOTE;
				1: b = CH_NEWLINE;
				2: b = cur_sep;
				default: b = 8'($urandom_range(0, 255));
			endcase
			send_byte(b, $urandom_range(0, 15) == 0);
		end
	endtask

	initial begin
		int target;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_beats[i])
			send_byte(directed_beats[i][7:0], directed_beats[i][8]);

		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p > 0)
				write_separator(phase_seps[p]);
			tx_idle = (p != 1 && p != 5);
			rx_idle <= (p != 1 && p != 6);
			target = sent_count + PHASE_BYTES;
			while (sent_count < target) begin
				if ($urandom_range(0, 7) == 0)
					send_noise();
				else
					send_record();
			end
		end

		s_tvalid <= 1'b0;
		@(negedge clk);
		while (pending_count != 0) @(negedge clk);
		repeat (10) @(posedge clk);

		$display("Covered %0d bytes in, %0d tokens out, %0d records, over %0d separators",
			bytes_in, results_out, records_out, NUM_PHASES);
		$display("including directed quoting corner cases and a %0d-cycle output stall",
			HOLD_CYCLES);
		if (fail_count == 0)
			$display("csv_byte_tokenizer_top test passed");
		else
			$display("csv_byte_tokenizer_top test failed");
		$finish;
	end

endmodule
